// ===== src/cia_pkg.sv =====
// Shared types, codes and helper functions for the complex interface adapter.
package cia_pkg;

  typedef enum logic [2:0] {
    CMD_READ     = 3'd0,
    CMD_WRITE    = 3'd1,
    CMD_SYS_TICK = 3'd2,
    CMD_TOD_TICK = 3'd3,
    CMD_CNT      = 3'd4,
    CMD_SP       = 3'd5,
    CMD_FLAG     = 3'd6,
    CMD_NOP      = 3'd7
  } cmd_t;

  localparam logic [3:0] REG_PRA   = 4'd0;
  localparam logic [3:0] REG_PRB   = 4'd1;
  localparam logic [3:0] REG_DDRA  = 4'd2;
  localparam logic [3:0] REG_DDRB  = 4'd3;
  localparam logic [3:0] REG_TALO  = 4'd4;
  localparam logic [3:0] REG_TAHI  = 4'd5;
  localparam logic [3:0] REG_TBLO  = 4'd6;
  localparam logic [3:0] REG_TBHI  = 4'd7;
  localparam logic [3:0] REG_TOD0  = 4'd8;
  localparam logic [3:0] REG_TOD1  = 4'd9;
  localparam logic [3:0] REG_TOD2  = 4'd10;
  localparam logic [3:0] REG_TOD3  = 4'd11;
  localparam logic [3:0] REG_SDR   = 4'd12;
  localparam logic [3:0] REG_ICR   = 4'd13;
  localparam logic [3:0] REG_CRA   = 4'd14;
  localparam logic [3:0] REG_CRB   = 4'd15;

  localparam logic [1:0] CFG_VARIANT = 2'd0;
  localparam logic [1:0] CFG_MASK_A  = 2'd1;
  localparam logic [1:0] CFG_MASK_B  = 2'd2;
  localparam logic [1:0] CFG_DDR_PRF = 2'd3;

  typedef struct packed {
    logic [2:0] command;
    logic [3:0] reg_addr;
    logic [7:0] bus_data;
    logic [7:0] port_a_pins;
    logic [7:0] port_b_pins;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_line;
    logic [7:0] port_a_drive;
    logic [7:0] port_b_drive;
    logic       serial_out;
    logic       count_pin;
  } result_t;

  function automatic logic [7:0] bcd_inc(input logic [7:0] v);
    logic [7:0] r;
    r = v + 8'd1;
    if (r[3:0] >= 4'ha) r = r + 8'd6;
    return r;
  endfunction

  // One tenth-second step of the BCD clock with the 12-hour wrap rules.
  function automatic logic [31:0] tod_bcd_next(input logic [31:0] t, input logic sec50);
    logic [7:0] sub;
    logic [7:0] sec;
    logic [7:0] mins;
    logic [7:0] hr;
    sub  = bcd_inc(t[7:0]);
    sec  = t[15:8];
    mins = t[23:16];
    hr   = t[31:24];
    if (sub >= 8'h10) begin
      sub = 8'h00;
      sec = bcd_inc(sec);
      if (sec >= (sec50 ? 8'h50 : 8'h60)) begin
        sec  = 8'h00;
        mins = bcd_inc(mins);
        if (mins >= 8'h60) begin
          mins = 8'h00;
          if (hr == 8'h91) hr = 8'h00;
          else if (hr == 8'h89) hr = 8'h90;
          else if (hr == 8'h11) hr = 8'h80;
          else if (hr == 8'h09) hr = 8'h10;
          else hr = hr + 8'd1;
        end
      end
    end
    return {hr, mins, sec, sub};
  endfunction

endpackage

// ===== src/cia_core.sv =====
// Register file, timers, time-of-day clock, serial shifter and interrupt logic.
module cia_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            go,
  input  cia_pkg::item_t  item,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_index,
  input  logic [7:0]      cfg_data,
  output cia_pkg::result_t result
);
  import cia_pkg::*;

  logic        variant;
  logic [7:0]  mask_a;
  logic [7:0]  mask_b;

  logic [7:0]  latch [2];
  logic [7:0]  sampled [2];
  logic [7:0]  driven [2];
  logic [7:0]  dir [2];
  logic [15:0] reload [2];
  logic [15:0] count [2];
  logic [7:0]  ctl [2];
  logic [31:0] tod;
  logic [31:0] snap;
  logic        held;
  logic        running;
  logic [23:0] alarm;
  logic [6:0]  ien;
  logic [6:0]  ist;
  logic        sloaded;
  logic [7:0]  sdr;
  logic        sline;
  logic        cline;
  logic [3:0]  scount;
  logic [7:0]  sreg;

  logic [7:0]  latch_next [2];
  logic [7:0]  sampled_next [2];
  logic [7:0]  driven_next [2];
  logic [7:0]  dir_next [2];
  logic [15:0] reload_next [2];
  logic [15:0] count_next [2];
  logic [7:0]  ctl_next [2];
  logic [31:0] tod_next;
  logic [31:0] snap_next;
  logic        held_next;
  logic        running_next;
  logic [23:0] alarm_next;
  logic [6:0]  ien_next;
  logic [6:0]  ist_next;
  logic        sloaded_next;
  logic [7:0]  sdr_next;
  logic        sline_next;
  logic        cline_next;
  logic [3:0]  scount_next;
  logic [7:0]  sreg_next;
  logic [7:0]  rd;

  always_comb begin
    logic       p;
    logic       bump_a;
    logic       bump_b;
    logic       a_uf;
    logic       rising;
    logic [7:0] d;
    logic [31:0] tsel;
    logic [31:0] tnew;
    cmd_t       cmd;
    latch_next   = latch;
    sampled_next = sampled;
    driven_next  = driven;
    dir_next     = dir;
    reload_next  = reload;
    count_next   = count;
    ctl_next     = ctl;
    tod_next     = tod;
    snap_next    = snap;
    held_next    = held;
    running_next = running;
    alarm_next   = alarm;
    ien_next     = ien;
    ist_next     = ist;
    sloaded_next = sloaded;
    sdr_next     = sdr;
    sline_next   = sline;
    cline_next   = cline;
    scount_next  = scount;
    sreg_next    = sreg;
    rd           = 8'h00;
    p            = item.reg_addr[0];
    bump_a       = 1'b0;
    bump_b       = 1'b0;
    rising       = 1'b0;
    d            = 8'h00;
    tsel         = 32'h0;
    tnew         = 32'h0;
    cmd          = cmd_t'(item.command);

    unique case (cmd)
      CMD_READ: begin
        unique case (item.reg_addr)
          REG_PRA, REG_PRB: begin
            d = ((p ? item.port_b_pins : item.port_a_pins) & ~dir[p]) | (latch[p] & dir[p]);
            d = d & (p ? mask_b : mask_a);
            sampled_next[p] = d;
            if (p) begin
              if (ctl[0][1]) d[6] = (count[0] != 16'h0);
              if (ctl[1][1]) d[7] = (count[1] != 16'h0);
            end
          end
          REG_DDRA, REG_DDRB: d = dir[p];
          REG_TALO: d = count[0][7:0];
          REG_TAHI: d = count[0][15:8];
          REG_TBLO: d = count[1][7:0];
          REG_TBHI: d = count[1][15:8];
          REG_TOD0, REG_TOD1, REG_TOD2, REG_TOD3: begin
            if (item.reg_addr == REG_TOD2) begin
              snap_next = tod;
              held_next = 1'b1;
            end else if (item.reg_addr == REG_TOD0) begin
              held_next = 1'b0;
            end
            tsel = held_next ? snap_next : tod;
            d = tsel[8*item.reg_addr[1:0] +: 8];
          end
          REG_SDR: d = sdr;
          REG_ICR: begin
            d = {|ist, ist};
            ist_next = 7'h0;
          end
          REG_CRA, REG_CRB: d = ctl[p];
          default: d = 8'h00;
        endcase
        rd = d;
      end
      CMD_WRITE: begin
        d = item.bus_data;
        unique case (item.reg_addr)
          REG_PRA, REG_PRB: begin
            latch_next[p]  = d;
            driven_next[p] = (d & dir[p]) | (sampled[p] & ~dir[p]);
          end
          REG_DDRA, REG_DDRB: dir_next[p] = d;
          REG_TALO: reload_next[0][7:0] = d;
          REG_TBLO: reload_next[1][7:0] = d;
          REG_TAHI, REG_TBHI: begin
            reload_next[item.reg_addr[1]][15:8] = d;
            if (ctl[item.reg_addr[1]][3]) begin
              ctl_next[item.reg_addr[1]][0] = 1'b1;
              count_next[item.reg_addr[1]]  = reload_next[item.reg_addr[1]];
            end else if (!ctl[item.reg_addr[1]][0]) begin
              count_next[item.reg_addr[1]]  = reload_next[item.reg_addr[1]];
            end
          end
          REG_TOD0, REG_TOD1, REG_TOD2: begin
            if (ctl[1][7]) begin
              alarm_next[8*item.reg_addr[1:0] +: 8] = d;
            end else begin
              tod_next[8*item.reg_addr[1:0] +: 8] = d;
              running_next = (item.reg_addr == REG_TOD0);
            end
          end
          REG_TOD3: ;
          REG_SDR: begin
            sdr_next = d;
            if (ctl[0][6]) sloaded_next = 1'b1;
          end
          REG_ICR: begin
            if (d[7]) ien_next = ien | d[6:0];
            else ien_next = ien & ~d[6:0];
          end
          REG_CRA, REG_CRB: begin
            ctl_next[p] = d & 8'hef;
            if (d[4]) count_next[p] = reload[p];
          end
          default: ;
        endcase
      end
      CMD_SYS_TICK: begin
        bump_a = (ctl[0] & 8'h21) == 8'h01;
        bump_b = (ctl[1] & 8'h61) == 8'h01;
      end
      CMD_TOD_TICK: begin
        if (running) begin
          tnew = variant ? {8'h00, tod[23:0] + 24'd1} : tod_bcd_next(tod, ctl[0][7]);
          tod_next = tnew;
          if (tnew == {8'h00, alarm}) ist_next[2] = 1'b1;
        end
      end
      CMD_CNT: begin
        rising = !cline && item.bus_data[0];
        bump_a = rising && ((ctl[0] & 8'h21) == 8'h21);
        bump_b = rising && ((ctl[1] & 8'h61) == 8'h21);
      end
      CMD_SP: sline_next = item.bus_data[0];
      CMD_FLAG: ist_next[4] = 1'b1;
      default: ;
    endcase

    // Timer A, with its cascade into timer B and the serial output clock.
    a_uf = bump_a && (count[0] == 16'h0);
    if (bump_a) begin
      if (a_uf) begin
        ist_next[0] = 1'b1;
        if (ctl[0][3]) ctl_next[0][0] = 1'b0;
        count_next[0] = reload[0];
      end else begin
        count_next[0] = count[0] - 16'd1;
      end
    end
    if (a_uf && ((ctl[1] & 8'h41) == 8'h41) && (cline || !ctl[1][5])) bump_b = 1'b1;
    if (bump_b) begin
      if (count[1] == 16'h0) begin
        ist_next[1] = 1'b1;
        if (ctl[1][3]) ctl_next[1][0] = 1'b0;
        count_next[1] = reload[1];
      end else begin
        count_next[1] = count[1] - 16'd1;
      end
    end
    if (a_uf && ctl[0][6] && (scount != 4'd0 || sloaded)) begin
      if (cline) begin
        sreg_next = sreg;
        if (scount == 4'd0) begin
          sloaded_next = 1'b0;
          sreg_next    = sdr;
        end
        sline_next  = sreg_next[7];
        scount_next = scount + 4'd1;
        sreg_next   = {sreg_next[6:0], 1'b0};
        cline_next  = 1'b0;
      end else begin
        cline_next = 1'b1;
        if (scount == 4'd8) begin
          scount_next = 4'd0;
          ist_next[3] = 1'b1;
        end
      end
    end

    // Serial input is clocked on the rising CNT edge.
    if (cmd == CMD_CNT) begin
      if (rising && !ctl[0][6]) begin
        sreg_next   = {sreg[6:0], sline};
        scount_next = scount + 4'd1;
        if (scount_next == 4'd8) begin
          sdr_next    = sreg_next;
          sreg_next   = 8'h00;
          scount_next = 4'd0;
          ist_next[3] = 1'b1;
        end
      end
      cline_next = item.bus_data[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      variant <= 1'b0;
      mask_a  <= 8'hff;
      mask_b  <= 8'hff;
      for (int i = 0; i < 2; i++) begin
        latch[i]   <= 8'h00;
        sampled[i] <= 8'h00;
        driven[i]  <= 8'h00;
        dir[i]     <= 8'hff;
        reload[i]  <= 16'hffff;
        count[i]   <= 16'h0000;
        ctl[i]     <= 8'h00;
      end
      tod     <= 32'h0;
      snap    <= 32'h0;
      held    <= 1'b0;
      running <= 1'b1;
      alarm   <= 24'h0;
      ien     <= 7'h0;
      ist     <= 7'h0;
      sloaded <= 1'b0;
      sdr     <= 8'h00;
      sline   <= 1'b0;
      cline   <= 1'b0;
      scount  <= 4'd0;
      sreg    <= 8'h00;
    end else if (go) begin
      latch   <= latch_next;
      sampled <= sampled_next;
      driven  <= driven_next;
      dir     <= dir_next;
      reload  <= reload_next;
      count   <= count_next;
      ctl     <= ctl_next;
      tod     <= tod_next;
      snap    <= snap_next;
      held    <= held_next;
      running <= running_next;
      alarm   <= alarm_next;
      ien     <= ien_next;
      ist     <= ist_next;
      sloaded <= sloaded_next;
      sdr     <= sdr_next;
      sline   <= sline_next;
      cline   <= cline_next;
      scount  <= scount_next;
      sreg    <= sreg_next;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_VARIANT: variant <= cfg_data[0];
        CFG_MASK_A:  mask_a  <= cfg_data;
        CFG_MASK_B:  mask_b  <= cfg_data;
        CFG_DDR_PRF: begin
          // The profile only matters at the moment it is written.
          dir[0] <= cfg_data[0] ? 8'hff : 8'h03;
          dir[1] <= cfg_data[0] ? 8'hff : 8'h00;
        end
        default: ;
      endcase
    end
  end

  assign result.read_data    = rd;
  assign result.irq_line     = |(ist_next & ien_next);
  assign result.port_a_drive = driven_next[0];
  assign result.port_b_drive = driven_next[1];
  assign result.serial_out   = sline_next;
  assign result.count_pin    = cline_next;

endmodule

// ===== src/complex_interface_adapter.sv =====
// Top level of the complex interface adapter: input register, core and result register.
// Usage: each transfer on the input channel (in_valid high, in_stall low) carries one
// command: bus read, bus write, system tick, time-of-day tick, CNT level, SP level,
// FLAG pulse or no-op. Every command yields exactly one result transfer on the output channel
// with the read data (zero for non-reads), the interrupt line and the pin levels.
// Each item is captured in the input register; the core then updates all state and
// loads the result register with its result once that register can take it.
// Throughput is one item per cycle unless the receiver stalls; it is set by the core's
// state update, as each command depends on the state left by the one before it.
// While the receiver stalls, the result register holds its transfer and the input
// register holds one more item; in_stall rises only when both are full.
// Configuration writes on the cfg channel are always ready; the user must issue them
// only while no item is in flight, as the block itself does not enforce this.
// Synchronous reset empties both registers and puts all adapter state in its power-on
// values: directions 0xff, timer latches 0xffff, clock running, interrupts cleared.
module complex_interface_adapter (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] command,
  input  logic [3:0] reg_addr,
  input  logic [7:0] bus_data,
  input  logic [7:0] port_a_pins,
  input  logic [7:0] port_b_pins,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] read_data,
  output logic       irq_line,
  output logic [7:0] port_a_drive,
  output logic [7:0] port_b_drive,
  output logic       serial_out,
  output logic       count_pin,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);
  import cia_pkg::*;

  logic    item_valid;
  item_t   item;
  logic    adv;
  result_t res_next;
  result_t res;

  assign adv       = item_valid && (!out_valid || !out_stall);
  assign in_stall  = item_valid && !adv;
  assign cfg_ready = 1'b1;

  cia_core u_core (
    .clk       (clk),
    .rst       (rst),
    .go        (adv),
    .item      (item),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .result    (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        item_valid <= 1'b1;
        item       <= '{command: command, reg_addr: reg_addr, bus_data: bus_data,
                        port_a_pins: port_a_pins, port_b_pins: port_b_pins};
      end else if (adv) begin
        item_valid <= 1'b0;
      end
      if (adv) begin
        out_valid <= 1'b1;
        res       <= res_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign read_data    = res.read_data;
  assign irq_line     = res.irq_line;
  assign port_a_drive = res.port_a_drive;
  assign port_b_drive = res.port_b_drive;
  assign serial_out   = res.serial_out;
  assign count_pin    = res.count_pin;

  a_stall_needs_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while the result register could drain");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result transfer was dropped");

  a_item_processed: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !out_valid) |=> out_valid)
    else $error("pending item did not reach the result register");

endmodule

// ===== tb/cia_checker.sv =====
// Checker for the interface adapter: predicts each result and compares it with the output.
module cia_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [2:0] command,
  input  logic [3:0] reg_addr,
  input  logic [7:0] bus_data,
  input  logic [7:0] port_a_pins,
  input  logic [7:0] port_b_pins,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] read_data,
  input  logic       irq_line,
  input  logic [7:0] port_a_drive,
  input  logic [7:0] port_b_drive,
  input  logic       serial_out,
  input  logic       count_pin,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  output int         fail_count,
  output int         pending,
  output int         result_count
);
  import cia_pkg::*;

  logic        binary_tod;
  logic [7:0]  mask_a, mask_b;
  logic        wide_profile;
  logic [7:0]  latch_q[2], sampled_q[2], driven_q[2], dir_q[2];
  logic [15:0] reload_q[2], count_q[2];
  logic [7:0]  ctrl_q[2];
  logic [31:0] tod_q, snap_q, alarm_q;
  logic        snap_held, tod_run;
  logic [6:0]  ie_q;
  logic [7:0]  is_q;
  logic        irq_q, sdr_loaded, sp_q, cnt_q;
  logic [7:0]  sdr_q, shreg_q;
  logic [3:0]  shcnt_q;
  result_t     expected_q[$];

  task automatic set_profile();
    dir_q[0] = wide_profile ? 8'hff : 8'h03;
    dir_q[1] = wide_profile ? 8'hff : 8'h00;
  endtask

  task automatic update_irq();
    is_q[7] = |is_q[6:0];
    irq_q = |(is_q[6:0] & ie_q);
  endtask

  task automatic power_on();
    binary_tod = 0; mask_a = 8'hff; mask_b = 8'hff; wide_profile = 1;
    for (int i = 0; i < 2; i++) begin
      latch_q[i] = 0; sampled_q[i] = 0; driven_q[i] = 0;
      reload_q[i] = 16'hffff; count_q[i] = 0; ctrl_q[i] = 0;
    end
    set_profile();
    tod_q = 0; snap_q = 0; alarm_q = 0; snap_held = 0; tod_run = 1;
    ie_q = 0; is_q = 0; irq_q = 0;
    sdr_loaded = 0; sdr_q = 0; sp_q = 0; cnt_q = 0; shcnt_q = 0; shreg_q = 0;
  endtask

  task automatic timer_reload(input int t);
    is_q[t] = 1'b1;
    update_irq();
    if (ctrl_q[t][3]) ctrl_q[t][0] = 1'b0;
    count_q[t] = reload_q[t];
  endtask

  task automatic step_timer_b();
    if (count_q[1] == 0) timer_reload(1);
    else count_q[1] = count_q[1] - 16'd1;
  endtask

  task automatic timer_a_underflow();
    timer_reload(0);
    if ((ctrl_q[1] & 8'h41) == 8'h41 && (cnt_q || !ctrl_q[1][5])) step_timer_b();
    if (ctrl_q[0][6] && (shcnt_q != 0 || sdr_loaded)) begin
      if (cnt_q) begin
        if (shcnt_q == 0) begin
          sdr_loaded = 0;
          shreg_q = sdr_q;
        end
        sp_q = shreg_q[7];
        shcnt_q = shcnt_q + 4'd1;
        shreg_q = shreg_q << 1;
        cnt_q = 0;
      end else begin
        cnt_q = 1;
        if (shcnt_q == 4'd8) begin
          shcnt_q = 0;
          is_q[3] = 1'b1;
          update_irq();
        end
      end
    end
  endtask

  task automatic step_timer_a();
    if (count_q[0] == 0) timer_a_underflow();
    else count_q[0] = count_q[0] - 16'd1;
  endtask

  function automatic logic [7:0] next_bcd(input logic [7:0] v);
    logic [7:0] r;
    r = v + 8'd1;
    if (r[3:0] >= 4'ha) r = r + 8'd6;
    return r;
  endfunction

  task automatic advance_tod();
    logic [7:0] sub, sec, mins, hr;
    if (!tod_run) return;
    if (binary_tod) tod_q = (tod_q + 32'd1) & 32'hffffff;
    else begin
      sub = next_bcd(tod_q[7:0]); sec = tod_q[15:8];
      mins = tod_q[23:16]; hr = tod_q[31:24];
      if (sub >= 8'h10) begin
        sub = 0;
        sec = next_bcd(sec);
        if (sec >= (ctrl_q[0][7] ? 8'h50 : 8'h60)) begin
          sec = 0;
          mins = next_bcd(mins);
          if (mins >= 8'h60) begin
            mins = 0;
            case (hr)
              8'h91: hr = 8'h00;
              8'h89: hr = 8'h90;
              8'h11: hr = 8'h80;
              8'h09: hr = 8'h10;
              default: hr = hr + 8'd1;
            endcase
          end
        end
      end
      tod_q = {hr, mins, sec, sub};
    end
    if (tod_q == alarm_q) begin
      is_q[2] = 1'b1;
      update_irq();
    end
  endtask

  task automatic count_edge(input logic lvl);
    if (!cnt_q && lvl) begin
      if ((ctrl_q[0] & 8'h21) == 8'h21) step_timer_a();
      if ((ctrl_q[1] & 8'h61) == 8'h21) step_timer_b();
      if (!ctrl_q[0][6]) begin
        shreg_q = {shreg_q[6:0], sp_q};
        shcnt_q = shcnt_q + 4'd1;
        if (shcnt_q == 4'd8) begin
          sdr_q = shreg_q; shreg_q = 0; shcnt_q = 0;
          is_q[3] = 1'b1;
          update_irq();
        end
      end
    end
    cnt_q = lvl;
  endtask

  task automatic register_read(input logic [3:0] a, input logic [7:0] pa,
                               input logic [7:0] pb, output logic [7:0] d);
    int p;
    logic [31:0] tsel;
    d = 0;
    p = a[0];
    case (a)
      REG_PRA, REG_PRB: begin
        d = ((p ? pb : pa) & ~dir_q[p] | latch_q[p] & dir_q[p]) & (p ? mask_b : mask_a);
        sampled_q[p] = d;
        if (p) begin
          if (ctrl_q[0][1]) d[6] = (count_q[0] != 0);
          if (ctrl_q[1][1]) d[7] = (count_q[1] != 0);
        end
      end
      REG_DDRA, REG_DDRB: d = dir_q[p];
      REG_TALO, REG_TBLO: d = count_q[a[1]][7:0];
      REG_TAHI, REG_TBHI: d = count_q[a[1]][15:8];
      REG_TOD0, REG_TOD1, REG_TOD2, REG_TOD3: begin
        if (a == REG_TOD2) begin
          snap_q = tod_q; snap_held = 1;
        end else if (a == REG_TOD0) snap_held = 0;
        tsel = (snap_held ? snap_q : tod_q) >> (8 * a[1:0]);
        d = tsel[7:0];
      end
      REG_SDR: d = sdr_q;
      REG_ICR: begin
        d = is_q; is_q = 0;
        update_irq();
      end
      default: d = ctrl_q[p];
    endcase
  endtask

  task automatic register_write(input logic [3:0] a, input logic [7:0] d);
    int p, t, sh;
    p = a[0];
    t = a[1];
    sh = 8 * a[1:0];
    case (a)
      REG_PRA, REG_PRB: begin
        latch_q[p] = d;
        driven_q[p] = d & dir_q[p] | sampled_q[p] & ~dir_q[p];
      end
      REG_DDRA, REG_DDRB: dir_q[p] = d;
      REG_TALO, REG_TBLO: reload_q[t][7:0] = d;
      REG_TAHI, REG_TBHI: begin
        reload_q[t][15:8] = d;
        if (ctrl_q[t][3]) begin
          ctrl_q[t][0] = 1'b1;
          count_q[t] = reload_q[t];
        end else if (!ctrl_q[t][0]) count_q[t] = reload_q[t];
      end
      REG_TOD0, REG_TOD1, REG_TOD2: begin
        if (ctrl_q[1][7]) begin
          alarm_q = (alarm_q & ~(32'hff << sh) | {24'd0, d} << sh) & 32'hffffff;
        end else begin
          tod_q = tod_q & ~(32'hff << sh) | {24'd0, d} << sh;
          tod_run = (a == REG_TOD0);
        end
      end
      REG_TOD3: ;
      REG_SDR: begin
        sdr_q = d;
        if (ctrl_q[0][6]) sdr_loaded = 1;
      end
      REG_ICR: begin
        if (d[7]) ie_q = ie_q | d[6:0];
        else ie_q = ie_q & ~d[6:0];
        update_irq();
      end
      default: begin
        ctrl_q[p] = d & 8'hef;
        if (d[4]) count_q[p] = reload_q[p];
      end
    endcase
  endtask

  task automatic predict_item(input item_t it, output result_t r);
    r.read_data = 0;
    case (cmd_t'(it.command))
      CMD_READ: register_read(it.reg_addr, it.port_a_pins, it.port_b_pins, r.read_data);
      CMD_WRITE: register_write(it.reg_addr, it.bus_data);
      CMD_SYS_TICK: begin
        if ((ctrl_q[0] & 8'h21) == 8'h01) step_timer_a();
        if ((ctrl_q[1] & 8'h61) == 8'h01) step_timer_b();
      end
      CMD_TOD_TICK: advance_tod();
      CMD_CNT: count_edge(it.bus_data[0]);
      CMD_SP: sp_q = it.bus_data[0];
      CMD_FLAG: begin
        is_q[4] = 1'b1;
        update_irq();
      end
      default: ;
    endcase
    r.irq_line = irq_q;
    r.port_a_drive = driven_q[0];
    r.port_b_drive = driven_q[1];
    r.serial_out = sp_q;
    r.count_pin = cnt_q;
  endtask

  always @(posedge clk) begin
    result_t seen, want, pred;
    if (rst) begin
      power_on();
      expected_q.delete();
      fail_count <= 0;
      result_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_VARIANT: binary_tod = cfg_data[0];
          CFG_MASK_A: mask_a = cfg_data;
          CFG_MASK_B: mask_b = cfg_data;
          CFG_DDR_PRF: begin
            wide_profile = cfg_data[0];
            set_profile();
          end
        endcase
      end
      if (in_valid && !in_stall) begin
        predict_item({command, reg_addr, bus_data, port_a_pins, port_b_pins}, pred);
        expected_q.push_back(pred);
      end
      if (out_valid && !out_stall) begin
        seen = {read_data, irq_line, port_a_drive, port_b_drive, serial_out, count_pin};
        result_count <= result_count + 1;
        if (expected_q.size() == 0) begin
          $display("%0t: result with nothing expected, actual %h", $time, seen);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_q.pop_front();
          if (seen !== want) begin
            $display("%0t: mismatch expected rd=%h irq=%b pa=%h pb=%h sp=%b cnt=%b", $time,
                     want.read_data, want.irq_line, want.port_a_drive, want.port_b_drive,
                     want.serial_out, want.count_pin);
            $display("%0t:          actual rd=%h irq=%b pa=%h pb=%h sp=%b cnt=%b", $time,
                     seen.read_data, seen.irq_line, seen.port_a_drive, seen.port_b_drive,
                     seen.serial_out, seen.count_pin);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top for the interface adapter: stimulus, configuration phases and verdict.
module tb_top;
  import cia_pkg::*;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0, in_stall;
  logic [2:0] command = 3'd0;
  logic [3:0] reg_addr = 4'd0;
  logic [7:0] bus_data = 8'h00, port_a_pins = 8'h00, port_b_pins = 8'h00;
  logic       out_valid, out_stall = 1'b0;
  logic [7:0] read_data, port_a_drive, port_b_drive;
  logic       irq_line, serial_out, count_pin;
  logic       cfg_valid = 1'b0, cfg_ready;
  logic [1:0] cfg_index = 2'd0;
  logic [7:0] cfg_data = 8'h00;
  int         fail_count, pending, result_count;
  int         idle_pct = 30;
  bit         hold_off = 0;
  int         quiet_cycles = 0;
  int         sent = 0;

  always #10 clk = ~clk;

  complex_interface_adapter u_dut (.*);
  cia_checker u_chk (.*);

  // The receiver stalls at random, except during a long hold-off that fills the block.
  always @(negedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(99) < idle_pct);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 5000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send(input cmd_t c, input logic [3:0] a, input logic [7:0] d);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    command <= c; reg_addr <= a; bus_data <= d;
    port_a_pins <= 8'($urandom); port_b_pins <= 8'($urandom);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_config(input logic [1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random items, weighted toward timer ticks and register traffic.
  task automatic random_item();
    int k;
    logic [7:0] d;
    k = $urandom_range(99);
    d = 8'($urandom);
    if (k < 30) send(CMD_SYS_TICK, 4'($urandom), d);
    else if (k < 50) send(CMD_READ, 4'($urandom), d);
    else if (k < 62) begin
      // Control writes with small timer values keep underflows frequent.
      case ($urandom_range(5))
        0: send(CMD_WRITE, REG_TALO, 8'($urandom_range(6)));
        1: send(CMD_WRITE, REG_TBLO, 8'($urandom_range(6)));
        2: send(CMD_WRITE, REG_TAHI, $urandom_range(1) ? 8'h00 : d);
        3: send(CMD_WRITE, REG_TBHI, $urandom_range(1) ? 8'h00 : d);
        4: send(CMD_WRITE, REG_CRA, d);
        default: send(CMD_WRITE, REG_CRB, d);
      endcase
    end
    else if (k < 75) send(CMD_WRITE, 4'($urandom), d);
    else if (k < 83) send(CMD_TOD_TICK, 4'($urandom), d);
    else if (k < 90) send(CMD_CNT, 4'($urandom), d);
    else if (k < 95) send(CMD_SP, 4'($urandom), d);
    else if (k < 98) send(CMD_FLAG, 4'($urandom), d);
    else send(CMD_NOP, 4'($urandom), d);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: port, DDRA, timer A, CRA, TOD and ICR writes, port, TOD and ICR reads, every command, TOD rollovers.
    send(CMD_WRITE, REG_ICR, 8'hff);
    send(CMD_WRITE, REG_DDRA, 8'h0f);
    send(CMD_WRITE, REG_PRA, 8'hff);
    send(CMD_READ, REG_PRA, 8'h00);
    send(CMD_WRITE, REG_PRB, 8'h00);
    send(CMD_WRITE, REG_TALO, 8'h02);
    send(CMD_WRITE, REG_TAHI, 8'h00);
    send(CMD_WRITE, REG_CRA, 8'h5b);
    repeat (4) send(CMD_SYS_TICK, 4'd0, 8'h00);
    send(CMD_READ, REG_PRB, 8'h00);
    send(CMD_WRITE, REG_TOD3, 8'h11);
    send(CMD_WRITE, REG_TOD2, 8'h59);
    send(CMD_WRITE, REG_TOD1, 8'h59);
    send(CMD_WRITE, REG_TOD0, 8'h09);
    send(CMD_TOD_TICK, 4'd0, 8'h00);
    send(CMD_READ, REG_TOD2, 8'h00);
    send(CMD_READ, REG_TOD3, 8'h00);
    send(CMD_READ, REG_TOD0, 8'h00);
    send(CMD_CNT, 4'd0, 8'h01);
    send(CMD_SP, 4'd0, 8'h01);
    send(CMD_FLAG, 4'd0, 8'h00);
    send(CMD_NOP, 4'd0, 8'hff);
    send(CMD_READ, REG_ICR, 8'h00);
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      set_config(CFG_VARIANT, 8'(phase[0]));
      set_config(CFG_MASK_A, phase == 1 ? 8'h00 : (phase == 2 ? 8'hff : 8'($urandom)));
      set_config(CFG_MASK_B, phase == 3 ? 8'h00 : (phase == 4 ? 8'hff : 8'($urandom)));
      set_config(CFG_DDR_PRF, 8'(phase[1]));
      idle_pct = (phase == 2) ? 0 : 30;
      if (phase == 4) begin
        fork
          begin
            hold_off = 1;
            repeat (60) @(negedge clk);
            hold_off = 0;
          end
          repeat (20) random_item();
        join
      end
      repeat (95) random_item();
      drain();
    end

    repeat (10) @(negedge clk);
    $display("Sent %0d items over six configuration phases; %0d results checked.",
             sent, result_count);
    if (fail_count == 0 && pending == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/cia_pkg.sv
src/cia_core.sv
src/complex_interface_adapter.sv
tb/cia_checker.sv
tb/tb_top.sv
